// ===== rtl/core/atc_pkg.sv =====
`timescale 1ns / 1ps

package atc_pkg;

    typedef logic [1:0] row_t;
    typedef logic [3:0] load_idx_t;

    typedef struct packed {
        logic valid;
        row_t row;
    } beat_ctl_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ROW  = 1'b1;

    localparam row_t ROW_TRANSLATION = 2'd3;

    localparam int NUM_AXES    = 3;
    localparam int NUM_LINEAR  = 9;
    localparam int NUM_OFFSET  = 3;
    localparam int OFFSET_BASE = 9;

    // width that holds three full products plus the scaled offset exactly
    function automatic int sum_bits(input int word_bits, input int frac_bits);
        int w;
        begin
            w = (2 * word_bits > word_bits + frac_bits) ? 2 * word_bits
                                                        : word_bits + frac_bits;
            return w + 2;
        end
    endfunction

endpackage

// ===== rtl/core/atc_req_if.sv =====
`timescale 1ns / 1ps

interface atc_req_if #(
    parameter int WORD_BITS = 32
) ();
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    atc_pkg::load_idx_t          load_index;
    logic signed [WORD_BITS-1:0] load_value;
    atc_pkg::row_t               row_index;
    logic signed [WORD_BITS-1:0] elem_x;
    logic signed [WORD_BITS-1:0] elem_y;
    logic signed [WORD_BITS-1:0] elem_z;

    modport source (
        output valid, req_type, load_index, load_value, row_index,
               elem_x, elem_y, elem_z,
        input  ready
    );

    modport sink (
        input  valid, req_type, load_index, load_value, row_index,
               elem_x, elem_y, elem_z,
        output ready
    );
endinterface

// ===== rtl/core/atc_res_if.sv =====
`timescale 1ns / 1ps

interface atc_res_if #(
    parameter int WORD_BITS = 32
) ();
    logic                        valid;
    logic                        ready;
    atc_pkg::row_t               out_row;
    logic signed [WORD_BITS-1:0] res_x;
    logic signed [WORD_BITS-1:0] res_y;
    logic signed [WORD_BITS-1:0] res_z;
    logic                        saturated;

    modport source (
        output valid, out_row, res_x, res_y, res_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_row, res_x, res_y, res_z, saturated,
        output ready
    );
endinterface

// ===== rtl/core/atc_coef_store.sv =====
`timescale 1ns / 1ps

module atc_coef_store #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_en,
    input  atc_pkg::load_idx_t          load_index,
    input  logic signed [WORD_BITS-1:0] load_value,
    output logic signed [WORD_BITS-1:0] linear [atc_pkg::NUM_LINEAR],
    output logic signed [WORD_BITS-1:0] offset [atc_pkg::NUM_OFFSET]
);

    localparam logic [WORD_BITS-1:0] ONE_Q = {{(WORD_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [WORD_BITS-1:0] lin_reg [atc_pkg::NUM_LINEAR];
    logic signed [WORD_BITS-1:0] off_reg [atc_pkg::NUM_OFFSET];

    for (genvar g = 0; g < atc_pkg::NUM_LINEAR; g++) begin : g_lin
        localparam bit DIAG = (g % 4 == 0);
        logic we;

        assign we = load_en && (load_index == atc_pkg::load_idx_t'(g));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lin_reg[g] <= DIAG ? ONE_Q : '0;
            end
            else if (we)
            begin
                lin_reg[g] <= load_value;
            end
        end
    end

    for (genvar g = 0; g < atc_pkg::NUM_OFFSET; g++) begin : g_off
        logic we;

        assign we = load_en
                    && (load_index == atc_pkg::load_idx_t'(atc_pkg::OFFSET_BASE + g));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                off_reg[g] <= '0;
            end
            else if (we)
            begin
                off_reg[g] <= load_value;
            end
        end
    end

    assign linear = lin_reg;
    assign offset = off_reg;

endmodule

// ===== rtl/core/atc_mult.sv =====
`timescale 1ns / 1ps

// Stage 1: each product split into a low half (unsigned) and a high half.
// Stage 2: halves recombined into full 2W-bit products.
module atc_mult #(
    parameter int WORD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  atc_pkg::beat_ctl_t            in_ctl,
    output logic                          in_ready,
    input  logic signed [WORD_BITS-1:0]   elem   [atc_pkg::NUM_AXES],
    input  logic signed [WORD_BITS-1:0]   linear [atc_pkg::NUM_LINEAR],
    input  logic signed [WORD_BITS-1:0]   offset [atc_pkg::NUM_OFFSET],
    output atc_pkg::beat_ctl_t            out_ctl,
    input  logic                          out_ready,
    output logic signed [2*WORD_BITS-1:0] prod [atc_pkg::NUM_AXES][atc_pkg::NUM_AXES],
    output logic signed [WORD_BITS-1:0]   prod_off [atc_pkg::NUM_AXES]
);

    localparam int W   = WORD_BITS;
    localparam int H   = WORD_BITS / 2;
    localparam int PW  = 2 * WORD_BITS;
    localparam int LOW = W + H + 1;
    localparam int HIW = PW - H;
    localparam int N   = atc_pkg::NUM_AXES;

    logic               v1_reg;
    atc_pkg::row_t      row1_reg;
    logic signed [LOW-1:0] plo_reg  [N][N];
    logic signed [LOW-1:0] plo_next [N][N];
    logic signed [HIW-1:0] phi_reg  [N][N];
    logic signed [HIW-1:0] phi_next [N][N];
    logic signed [W-1:0]   off1_reg  [N];
    logic signed [W-1:0]   off1_next [N];

    logic               v2_reg;
    atc_pkg::row_t      row2_reg;
    logic signed [PW-1:0] prod_reg  [N][N];
    logic signed [PW-1:0] prod_next [N][N];
    logic signed [W-1:0]  off2_reg [N];

    logic rdy1;
    logic rdy2;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // prod[j][k] = elem[k] * linear[k][j]
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            for (int k = 0; k < N; k++)
            begin
                plo_next[j][k] = elem[k]
                                 * $signed({1'b0, linear[k*N + j][H-1:0]});
                phi_next[j][k] = elem[k] * $signed(linear[k*N + j][W-1:H]);
            end
            off1_next[j] = (in_ctl.row == atc_pkg::ROW_TRANSLATION) ? offset[j] : '0;
        end
    end

    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            for (int k = 0; k < N; k++)
            begin
                prod_next[j][k] = (PW'(phi_reg[j][k]) <<< H) + PW'(plo_reg[j][k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_ctl.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_ctl.valid)
        begin
            row1_reg <= in_ctl.row;
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            off1_reg <= off1_next;
        end
        if (rdy2 && v1_reg)
        begin
            row2_reg <= row1_reg;
            prod_reg <= prod_next;
            off2_reg <= off1_reg;
        end
    end

    assign out_ctl.valid = v2_reg;
    assign out_ctl.row   = row2_reg;
    assign prod          = prod_reg;
    assign prod_off      = off2_reg;

endmodule

// ===== rtl/core/atc_accum.sv =====
`timescale 1ns / 1ps

// Stage 3: exact column sums of the three products plus the scaled offset.
module atc_accum #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  atc_pkg::beat_ctl_t            in_ctl,
    output logic                          in_ready,
    input  logic signed [2*WORD_BITS-1:0] prod [atc_pkg::NUM_AXES][atc_pkg::NUM_AXES],
    input  logic signed [WORD_BITS-1:0]   prod_off [atc_pkg::NUM_AXES],
    output atc_pkg::beat_ctl_t            out_ctl,
    input  logic                          out_ready,
    output logic signed [atc_pkg::sum_bits(WORD_BITS, FRAC_BITS)-1:0] sum [atc_pkg::NUM_AXES]
);

    localparam int SW = atc_pkg::sum_bits(WORD_BITS, FRAC_BITS);
    localparam int N  = atc_pkg::NUM_AXES;

    logic                 v_reg;
    atc_pkg::row_t        row_reg;
    logic signed [SW-1:0] sum_reg  [N];
    logic signed [SW-1:0] sum_next [N];
    logic                 rdy;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            sum_next[j] = SW'(prod[j][0]) + SW'(prod[j][1]) + SW'(prod[j][2])
                          + (SW'(prod_off[j]) <<< FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (rdy)
        begin
            v_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_ctl.valid)
        begin
            row_reg <= in_ctl.row;
            sum_reg <= sum_next;
        end
    end

    assign out_ctl.valid = v_reg;
    assign out_ctl.row   = row_reg;
    assign sum           = sum_reg;

endmodule

// ===== rtl/core/atc_narrow.sv =====
`timescale 1ns / 1ps

// Stage 4: round half up, drop fraction bits, clamp to word range.
module atc_narrow #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  atc_pkg::beat_ctl_t          in_ctl,
    output logic                        in_ready,
    input  logic signed [atc_pkg::sum_bits(WORD_BITS, FRAC_BITS)-1:0] sum [atc_pkg::NUM_AXES],
    output atc_pkg::beat_ctl_t          out_ctl,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] res [atc_pkg::NUM_AXES],
    output logic                        saturated
);

    localparam int SW = atc_pkg::sum_bits(WORD_BITS, FRAC_BITS);
    localparam int N  = atc_pkg::NUM_AXES;

    localparam logic signed [SW-1:0] HALF =
        ({{(SW-1){1'b0}}, 1'b1} << FRAC_BITS) >> 1;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = -SMAX - 1;
    localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic                        v_reg;
    atc_pkg::row_t               row_reg;
    logic signed [WORD_BITS-1:0] res_reg  [N];
    logic signed [WORD_BITS-1:0] res_next [N];
    logic                        sat_reg;
    logic                        sat_next;
    logic                        rdy;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    always_comb
    begin
        logic signed [SW-1:0] rnd;
        logic signed [SW-1:0] shv;
        sat_next = 1'b0;
        for (int j = 0; j < N; j++)
        begin
            rnd = sum[j] + HALF;
            shv = rnd >>> FRAC_BITS;
            if (shv > SMAX)
            begin
                res_next[j] = WMAX;
                sat_next    = 1'b1;
            end
            else if (shv < SMIN)
            begin
                res_next[j] = WMIN;
                sat_next    = 1'b1;
            end
            else
            begin
                res_next[j] = shv[WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (rdy)
        begin
            v_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_ctl.valid)
        begin
            row_reg <= in_ctl.row;
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign out_ctl.valid = v_reg;
    assign out_ctl.row   = row_reg;
    assign res           = res_reg;
    assign saturated     = sat_reg;

endmodule

// ===== rtl/core/affine_transform_compose.sv =====
`timescale 1ns / 1ps

// Composes a streamed affine transform with a stored one, in signed fixed point
// (FRAC_BITS fraction bits in WORD_BITS-bit words). Load beats (req_type 0) write
// one entry of the stored transform: indexes 0-8 are its 3x3 linear part,
// row-major, 9-11 its translation, 12-15 are ignored; after reset it is the
// identity. Row beats (req_type 1) carry one row of the first transform (row 3
// is its translation) and return one result beat with the composed row, rounded
// half up and clamped, with saturated set if any element was clamped. Loads
// return nothing and take effect for the next row beat. One beat is accepted
// every cycle unless a stall on rsp has backed up the pipeline; a row's result
// passes through the four register stages: split multiply, product recombine,
// column sum, round and clamp. A stall on rsp holds the pipeline without loss.
module affine_transform_compose #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    atc_req_if.sink   req,
    atc_res_if.source rsp
);

    localparam int SW = atc_pkg::sum_bits(WORD_BITS, FRAC_BITS);
    localparam int N  = atc_pkg::NUM_AXES;

    logic                          load_en;
    logic signed [WORD_BITS-1:0]   elem   [N];
    logic signed [WORD_BITS-1:0]   linear [atc_pkg::NUM_LINEAR];
    logic signed [WORD_BITS-1:0]   offset [atc_pkg::NUM_OFFSET];

    atc_pkg::beat_ctl_t            in_ctl;
    atc_pkg::beat_ctl_t            mul_ctl;
    atc_pkg::beat_ctl_t            acc_ctl;
    atc_pkg::beat_ctl_t            nar_ctl;
    logic                          mul_in_ready;
    logic                          acc_in_ready;
    logic                          nar_in_ready;

    logic signed [2*WORD_BITS-1:0] prod [N][N];
    logic signed [WORD_BITS-1:0]   prod_off [N];
    logic signed [SW-1:0]          sum [N];
    logic signed [WORD_BITS-1:0]   res [N];

    assign load_en = req.valid && req.ready && (req.req_type == atc_pkg::REQ_LOAD);

    assign in_ctl.valid = req.valid && (req.req_type == atc_pkg::REQ_ROW);
    assign in_ctl.row   = req.row_index;
    assign req.ready    = mul_in_ready;

    assign elem[0] = req.elem_x;
    assign elem[1] = req.elem_y;
    assign elem[2] = req.elem_z;

    atc_coef_store #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_coef (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_en),
        .load_index (req.load_index),
        .load_value (req.load_value),
        .linear     (linear),
        .offset     (offset)
    );

    atc_mult #(
        .WORD_BITS (WORD_BITS)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (in_ctl),
        .in_ready  (mul_in_ready),
        .elem      (elem),
        .linear    (linear),
        .offset    (offset),
        .out_ctl   (mul_ctl),
        .out_ready (acc_in_ready),
        .prod      (prod),
        .prod_off  (prod_off)
    );

    atc_accum #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (mul_ctl),
        .in_ready  (acc_in_ready),
        .prod      (prod),
        .prod_off  (prod_off),
        .out_ctl   (acc_ctl),
        .out_ready (nar_in_ready),
        .sum       (sum)
    );

    atc_narrow #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_narrow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (acc_ctl),
        .in_ready  (nar_in_ready),
        .sum       (sum),
        .out_ctl   (nar_ctl),
        .out_ready (rsp.ready),
        .res       (res),
        .saturated (rsp.saturated)
    );

    assign rsp.valid   = nar_ctl.valid;
    assign rsp.out_row = nar_ctl.row;
    assign rsp.res_x   = res[0];
    assign rsp.res_y   = res[1];
    assign rsp.res_z   = res[2];

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int WORD = 32;
    localparam int FRAC = 16;
    localparam int ACC_BITS = 68;
    localparam int RANDOM_ITEMS = 1425;
    localparam int QUIET_TAIL = 150;

    typedef logic signed [WORD-1:0]     word_t;
    typedef logic signed [ACC_BITS-1:0] acc_t;

    typedef struct packed {
        logic               req_type;
        atc_pkg::load_idx_t load_index;
        word_t              load_value;
        atc_pkg::row_t      row_index;
        word_t              elem_x;
        word_t              elem_y;
        word_t              elem_z;
    } req_beat_t;

    typedef struct packed {
        atc_pkg::row_t row;
        word_t         x;
        word_t         y;
        word_t         z;
        logic          sat;
    } composed_row_t;

    typedef struct packed {
        req_beat_t     beat;
        logic          known;
        composed_row_t want;
    } stim_entry_t;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;
    localparam word_t ONE_Q    = 32'sh0001_0000;
    localparam word_t HALF_LSB = 32'sh0000_8000;

    localparam atc_pkg::load_idx_t IDX_M00       = 4'd0;
    localparam atc_pkg::load_idx_t IDX_M10       = 4'd3;
    localparam atc_pkg::load_idx_t IDX_M11       = 4'd4;
    localparam atc_pkg::load_idx_t IDX_M20       = 4'd6;
    localparam atc_pkg::load_idx_t IDX_OFF_X     = 4'(atc_pkg::OFFSET_BASE);
    localparam atc_pkg::load_idx_t IDX_OFF_Y     = 4'(atc_pkg::OFFSET_BASE + 1);
    localparam atc_pkg::load_idx_t IDX_OFF_Z     = 4'(atc_pkg::OFFSET_BASE + 2);
    localparam atc_pkg::load_idx_t IDX_UNUSED_LO = 4'd12;
    localparam atc_pkg::load_idx_t IDX_UNUSED_HI = 4'd15;

    logic clk;
    logic rst_n;

    atc_req_if #(.WORD_BITS(WORD)) req_bus ();
    atc_res_if #(.WORD_BITS(WORD)) rsp_bus ();

    affine_transform_compose #(
        .WORD_BITS(WORD),
        .FRAC_BITS(FRAC)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    word_t         xform_linear [atc_pkg::NUM_LINEAR];
    word_t         xform_offset [atc_pkg::NUM_OFFSET];
    composed_row_t pending_rows [$];
    stim_entry_t   directed_table [$];

    bit src_gaps;
    bit sink_gaps;
    int stall_left;
    int mismatches;
    int rows_checked;
    int rows_clipped;
    int loads_applied;
    int loads_ignored;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d rows still outstanding", pending_rows.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void reset_stored_xform();
        for (int i = 0; i < atc_pkg::NUM_LINEAR; i++)
            xform_linear[i] = (i % 4 == 0) ? ONE_Q : '0;
        for (int i = 0; i < atc_pkg::NUM_OFFSET; i++)
            xform_offset[i] = '0;
    endfunction

    function automatic void store_entry(atc_pkg::load_idx_t idx, word_t value);
        if (idx < atc_pkg::NUM_LINEAR)
            xform_linear[idx] = value;
        else if (idx < atc_pkg::OFFSET_BASE + atc_pkg::NUM_OFFSET)
            xform_offset[idx - atc_pkg::OFFSET_BASE] = value;
    endfunction

    function automatic composed_row_t compose_row(atc_pkg::row_t row, word_t ex, word_t ey,
                                                  word_t ez);
        word_t         e [atc_pkg::NUM_AXES];
        word_t         res [atc_pkg::NUM_AXES];
        acc_t          acc;
        composed_row_t r;
        e[0] = ex;
        e[1] = ey;
        e[2] = ez;
        r.sat = 1'b0;
        for (int j = 0; j < atc_pkg::NUM_AXES; j++)
        begin
            acc = '0;
            for (int k = 0; k < atc_pkg::NUM_AXES; k++)
                acc = acc + acc_t'(e[k]) * acc_t'(xform_linear[k * atc_pkg::NUM_AXES + j]);
            if (row == atc_pkg::ROW_TRANSLATION)
                acc = acc + (acc_t'(xform_offset[j]) <<< FRAC);
            acc = (acc + (acc_t'(1) <<< (FRAC - 1))) >>> FRAC;
            if (acc > acc_t'(WORD_MAX))
            begin
                res[j] = WORD_MAX;
                r.sat  = 1'b1;
            end
            else if (acc < acc_t'(WORD_MIN))
            begin
                res[j] = WORD_MIN;
                r.sat  = 1'b1;
            end
            else
                res[j] = word_t'(acc);
        end
        r.row = row;
        r.x   = res[0];
        r.y   = res[1];
        r.z   = res[2];
        return r;
    endfunction

    function automatic stim_entry_t load_entry(atc_pkg::load_idx_t idx, word_t value);
        stim_entry_t s;
        s                 = '0;
        s.beat.req_type   = atc_pkg::REQ_LOAD;
        s.beat.load_index = idx;
        s.beat.load_value = value;
        return s;
    endfunction

    function automatic stim_entry_t row_entry(atc_pkg::row_t row, word_t ex, word_t ey,
                                              word_t ez);
        stim_entry_t s;
        s                = '0;
        s.beat.req_type  = atc_pkg::REQ_ROW;
        s.beat.row_index = row;
        s.beat.elem_x    = ex;
        s.beat.elem_y    = ey;
        s.beat.elem_z    = ez;
        return s;
    endfunction

    function automatic stim_entry_t row_known(atc_pkg::row_t row, word_t ex, word_t ey,
                                              word_t ez, word_t rx, word_t ry, word_t rz,
                                              logic sat);
        stim_entry_t s;
        s        = row_entry(row, ex, ey, ez);
        s.known  = 1'b1;
        s.want   = '{row, rx, ry, rz, sat};
        return s;
    endfunction

    function automatic word_t rand_word();
        word_t specials [8];
        specials = '{WORD_MAX, WORD_MIN, '0, -32'sd1, 32'sd1, ONE_Q, HALF_LSB, -HALF_LSB};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return word_t'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            5, 6:          return word_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            7:             return word_t'($urandom);
            8:             return specials[$urandom_range(0, 7)];
            default:       return (word_t'($urandom_range(0, 8)) - 32'sd4) <<< FRAC;
        endcase
    endfunction

    task automatic issue_beat(input stim_entry_t s);
        composed_row_t predicted;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= s.beat.req_type;
        req_bus.load_index <= s.beat.load_index;
        req_bus.load_value <= s.beat.load_value;
        req_bus.row_index  <= s.beat.row_index;
        req_bus.elem_x     <= s.beat.elem_x;
        req_bus.elem_y     <= s.beat.elem_y;
        req_bus.elem_z     <= s.beat.elem_z;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        if (s.beat.req_type == atc_pkg::REQ_LOAD)
        begin
            store_entry(s.beat.load_index, s.beat.load_value);
            if (s.beat.load_index < atc_pkg::OFFSET_BASE + atc_pkg::NUM_OFFSET)
                loads_applied++;
            else
                loads_ignored++;
        end
        else
        begin
            predicted = compose_row(s.beat.row_index, s.beat.elem_x,
                                    s.beat.elem_y, s.beat.elem_z);
            pending_rows.push_back(s.known ? s.want : predicted);
        end
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
        end
        else if (sink_gaps && $urandom_range(0, 4) == 0)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            rsp_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        composed_row_t got;
        composed_row_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = '{rsp_bus.out_row, rsp_bus.res_x, rsp_bus.res_y, rsp_bus.res_z,
                    rsp_bus.saturated};
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat row %0d %h %h %h sat %b",
                             $realtime, got.row, got.x, got.y, got.z, got.sat);
            end
            else
            begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (want.sat)
                    rows_clipped++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: row mismatch: got %0d %h %h %h sat %b, exp %0d %h %h %h sat %b",
                                 $realtime, got.row, got.x, got.y, got.z, got.sat,
                                 want.row, want.x, want.y, want.z, want.sat);
                end
            end
        end
    end

    initial
    begin
        stim_entry_t s;
        int          issued;
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= atc_pkg::REQ_LOAD;
        req_bus.load_index <= '0;
        req_bus.load_value <= '0;
        req_bus.row_index  <= '0;
        req_bus.elem_x     <= '0;
        req_bus.elem_y     <= '0;
        req_bus.elem_z     <= '0;
        src_gaps   = 1'b1;
        sink_gaps  = 1'b1;
        reset_stored_xform();

        directed_table = {
            row_known(2'd0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 1'b0),
            row_known(atc_pkg::ROW_TRANSLATION, WORD_MAX, WORD_MIN, '0,
                      WORD_MAX, WORD_MIN, '0, 1'b0),
            row_known(2'd1, -32'sd1, 32'sd1, HALF_LSB, -32'sd1, 32'sd1, HALF_LSB, 1'b0),
            load_entry(IDX_UNUSED_LO, 32'sh1234_5678),
            load_entry(IDX_UNUSED_HI, -32'sd1),
            row_known(2'd2, 32'sd5, 32'sd6, 32'sd7, 32'sd5, 32'sd6, 32'sd7, 1'b0),
            load_entry(IDX_M00, WORD_MAX),
            row_known(2'd0, WORD_MAX, '0, '0, WORD_MAX, '0, '0, 1'b1),
            row_known(2'd0, WORD_MIN, '0, '0, WORD_MIN, '0, '0, 1'b1),
            load_entry(IDX_M00, WORD_MIN),
            row_known(2'd1, WORD_MIN, '0, '0, WORD_MAX, '0, '0, 1'b1),
            load_entry(IDX_OFF_X, WORD_MAX),
            load_entry(IDX_OFF_Y, WORD_MIN),
            load_entry(IDX_OFF_Z, ONE_Q),
            row_known(atc_pkg::ROW_TRANSLATION, '0, '0, '0, WORD_MAX, WORD_MIN, ONE_Q, 1'b0),
            row_known(2'd2, '0, '0, '0, '0, '0, '0, 1'b0),
            load_entry(IDX_M00, 32'sd1),
            // ties round up, just below a tie rounds down
            row_known(2'd0, HALF_LSB, '0, '0, 32'sd1, '0, '0, 1'b0),
            row_known(2'd0, -HALF_LSB, '0, '0, '0, '0, '0, 1'b0),
            row_known(2'd0, HALF_LSB - 32'sd1, '0, '0, '0, '0, '0, 1'b0),
            load_entry(IDX_M10, WORD_MIN),
            load_entry(IDX_M20, WORD_MIN),
            row_entry(2'd1, WORD_MIN, WORD_MIN, WORD_MIN),
            load_entry(IDX_M11, -ONE_Q),
            row_entry(atc_pkg::ROW_TRANSLATION, WORD_MAX, WORD_MAX, WORD_MAX)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
            issue_beat(directed_table[i]);

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued % 100 == 0)
            begin
                src_gaps  = (issued < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
                sink_gaps = (issued < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 6) == 0)
            begin
                s = load_entry(atc_pkg::load_idx_t'($urandom_range(0, 15)), rand_word());
                if (s.beat.load_index < atc_pkg::OFFSET_BASE + atc_pkg::NUM_OFFSET)
                    issued++;
            end
            else
            begin
                s = row_entry(atc_pkg::row_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                              rand_word());
                issued++;
            end
            issue_beat(s);
        end
        req_bus.valid <= 1'b0;
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;

        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Checked %0d composed rows (%0d clipped) across %0d stored-entry loads",
                 rows_checked, rows_clipped, loads_applied);
        $display("%0d loads to unused indexes, %0d mismatches", loads_ignored, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/atc_pkg.sv
rtl/core/atc_req_if.sv
rtl/core/atc_res_if.sv
rtl/core/atc_coef_store.sv
rtl/core/atc_mult.sv
rtl/core/atc_accum.sv
rtl/core/atc_narrow.sv
rtl/core/affine_transform_compose.sv
test/tb.sv
